// ===== rtl/bsub3_pkg.sv =====
// ----------------------------------------------------------------------------
// bsub3_pkg
// Shared constants and control types for the 3D box subtraction pipeline.
// ----------------------------------------------------------------------------
package bsub3_pkg;

    localparam int NUM_AXES   = 3;
    localparam int NUM_SLOTS  = 2 * NUM_AXES;   // low and high slab per axis
    localparam int NUM_COORDS = 4 * NUM_AXES;   // A lo/hi, B lo/hi

    // Per-request control that travels with the pieces down the pipeline.
    typedef struct packed {
        logic                 miss;      // B missed the remainder on some axis
        logic [NUM_SLOTS-1:0] slot_vld;  // which piece slots hold a result
    } slot_ctrl_t;

endpackage

// ===== rtl/bsub3_axis_stage.sv =====
// ----------------------------------------------------------------------------
// bsub3_axis_stage
// One pipeline stage: cuts the remainder box along one axis, fills that
// axis's low and high piece slots and shrinks the remainder.
// ----------------------------------------------------------------------------
module bsub3_axis_stage
    import bsub3_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int AXIS        = 0
)
(
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 in_valid,
    output logic                                                 in_ready,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                 in_a_lo,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                 in_a_hi,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                 in_b_lo,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                 in_b_hi,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                 in_r_lo,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                 in_r_hi,
    input  logic [NUM_SLOTS-1:0][NUM_AXES-1:0][COORD_WIDTH-1:0]  in_p_lo,
    input  logic [NUM_SLOTS-1:0][NUM_AXES-1:0][COORD_WIDTH-1:0]  in_p_hi,
    input  slot_ctrl_t                                           in_ctrl,
    output logic                                                 out_valid,
    input  logic                                                 out_ready,
    output logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                 out_a_lo,
    output logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                 out_a_hi,
    output logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                 out_b_lo,
    output logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                 out_b_hi,
    output logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                 out_r_lo,
    output logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                 out_r_hi,
    output logic [NUM_SLOTS-1:0][NUM_AXES-1:0][COORD_WIDTH-1:0]  out_p_lo,
    output logic [NUM_SLOTS-1:0][NUM_AXES-1:0][COORD_WIDTH-1:0]  out_p_hi,
    output slot_ctrl_t                                           out_ctrl
);

    localparam int LO_SLOT = 2 * AXIS;
    localparam int HI_SLOT = 2 * AXIS + 1;

    logic                                                vld_reg;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                a_lo_reg, a_hi_reg;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                b_lo_reg, b_hi_reg;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                r_lo_reg, r_hi_reg;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                r_lo_next, r_hi_next;
    logic [NUM_SLOTS-1:0][NUM_AXES-1:0][COORD_WIDTH-1:0] p_lo_reg, p_hi_reg;
    logic [NUM_SLOTS-1:0][NUM_AXES-1:0][COORD_WIDTH-1:0] p_lo_next, p_hi_next;
    slot_ctrl_t                                          ctrl_reg, ctrl_next;
    logic                                                miss_here;
    logic                                                cut_low;
    logic                                                cut_high;
    logic                                                load;

    assign in_ready = !vld_reg || out_ready;
    assign load     = in_valid && in_ready;

    assign miss_here = $signed(in_b_lo[AXIS]) > $signed(in_r_hi[AXIS])
                    || $signed(in_b_hi[AXIS]) < $signed(in_r_lo[AXIS]);
    assign cut_low   = $signed(in_b_lo[AXIS]) > $signed(in_r_lo[AXIS]);
    assign cut_high  = $signed(in_b_hi[AXIS]) < $signed(in_r_hi[AXIS]);

    always_comb
    begin
        r_lo_next = in_r_lo;
        r_hi_next = in_r_hi;
        p_lo_next = in_p_lo;
        p_hi_next = in_p_hi;
        ctrl_next = in_ctrl;
        if (!in_ctrl.miss)
        begin
            if (miss_here)
            begin
                // drop everything found so far, A goes out alone
                ctrl_next.miss     = 1'b1;
                ctrl_next.slot_vld = NUM_SLOTS'(1);
                p_lo_next[0]       = in_a_lo;
                p_hi_next[0]       = in_a_hi;
            end
            else
            begin
                if (cut_low)
                begin
                    p_lo_next[LO_SLOT]       = in_r_lo;
                    p_hi_next[LO_SLOT]       = in_r_hi;
                    p_hi_next[LO_SLOT][AXIS] = in_b_lo[AXIS] - COORD_WIDTH'(1);
                    ctrl_next.slot_vld[LO_SLOT] = 1'b1;
                    r_lo_next[AXIS]          = in_b_lo[AXIS];
                end
                if (cut_high)
                begin
                    // low bound already shrunk by the low slab
                    p_lo_next[HI_SLOT]       = r_lo_next;
                    p_hi_next[HI_SLOT]       = in_r_hi;
                    p_lo_next[HI_SLOT][AXIS] = in_b_hi[AXIS] + COORD_WIDTH'(1);
                    ctrl_next.slot_vld[HI_SLOT] = 1'b1;
                    r_hi_next[AXIS]          = in_b_hi[AXIS];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_lo_reg <= in_a_lo;
            a_hi_reg <= in_a_hi;
            b_lo_reg <= in_b_lo;
            b_hi_reg <= in_b_hi;
            r_lo_reg <= r_lo_next;
            r_hi_reg <= r_hi_next;
            p_lo_reg <= p_lo_next;
            p_hi_reg <= p_hi_next;
            ctrl_reg <= ctrl_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_a_lo  = a_lo_reg;
    assign out_a_hi  = a_hi_reg;
    assign out_b_lo  = b_lo_reg;
    assign out_b_hi  = b_hi_reg;
    assign out_r_lo  = r_lo_reg;
    assign out_r_hi  = r_hi_reg;
    assign out_p_lo  = p_lo_reg;
    assign out_p_hi  = p_hi_reg;
    assign out_ctrl  = ctrl_reg;

endmodule

// ===== rtl/bsub3_serializer.sv =====
// ----------------------------------------------------------------------------
// bsub3_serializer
// Holds one request's piece slots, sends the valid ones, or one empty result
// if none, lowest first, one per cycle unless stalled, via an output register.
// ----------------------------------------------------------------------------
module bsub3_serializer
    import bsub3_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 in_valid,
    output logic                                                 in_ready,
    input  logic [NUM_SLOTS-1:0][NUM_AXES-1:0][COORD_WIDTH-1:0]  in_p_lo,
    input  logic [NUM_SLOTS-1:0][NUM_AXES-1:0][COORD_WIDTH-1:0]  in_p_hi,
    input  slot_ctrl_t                                           in_ctrl,
    output logic                                                 out_valid,
    input  logic                                                 out_ready,
    output logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                 out_lo,
    output logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                 out_hi,
    output logic                                                 out_empty,
    output logic                                                 out_last
);

    logic                                                item_vld_reg;
    logic [NUM_SLOTS-1:0]                                pend_reg;
    logic [NUM_SLOTS-1:0][NUM_AXES-1:0][COORD_WIDTH-1:0] p_lo_reg, p_hi_reg;
    logic                                                out_vld_reg;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                out_lo_reg, out_hi_reg;
    logic                                                out_empty_reg;
    logic                                                out_last_reg;

    logic [NUM_SLOTS-1:0]                                sel;
    logic [NUM_SLOTS-1:0]                                rest;
    logic                                                is_last;
    logic                                                out_load;
    logic                                                emit;
    logic                                                load;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                lo_pick, hi_pick;

    // lowest pending slot, one-hot
    assign sel      = pend_reg & (~pend_reg + NUM_SLOTS'(1));
    assign rest     = pend_reg & ~sel;
    assign is_last  = (rest == '0);
    assign out_load = !out_vld_reg || out_ready;
    assign emit     = item_vld_reg && out_load;
    assign in_ready = !item_vld_reg || (emit && is_last);
    assign load     = in_valid && in_ready;

    // no slot selected on an empty difference: bounds come out as zero
    always_comb
    begin
        lo_pick = '0;
        hi_pick = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (sel[i])
            begin
                lo_pick = lo_pick | p_lo_reg[i];
                hi_pick = hi_pick | p_hi_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            pend_reg     <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                item_vld_reg <= 1'b1;
                pend_reg     <= in_ctrl.slot_vld;
            end
            else if (emit)
            begin
                item_vld_reg <= !is_last;
                pend_reg     <= rest;
            end

            if (emit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            p_lo_reg <= in_p_lo;
            p_hi_reg <= in_p_hi;
        end
        if (emit)
        begin
            out_lo_reg    <= lo_pick;
            out_hi_reg    <= hi_pick;
            out_empty_reg <= (pend_reg == '0);
            out_last_reg  <= is_last;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_lo    = out_lo_reg;
    assign out_hi    = out_hi_reg;
    assign out_empty = out_empty_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== rtl/box_subtract_3d.sv =====
// ----------------------------------------------------------------------------
// box_subtract_3d
// Difference of two inclusive integer boxes in 3D, as up to six pieces.
// ----------------------------------------------------------------------------
// Each request carries boxes A and B; the block returns A minus B as one to
// six disjoint boxes, or one result with tuser set when nothing is left.
// Three pipeline stages cut the remainder along x, y and z in turn, a fourth
// holds the finished request while its pieces go out, and the output is
// registered. A new request enters every cycle as long as each yields a single
// result and m_axis_tready stays high; a request with several pieces sends them
// one per cycle while m_axis_tready is high, and the next request is taken by
// the final stage as the last piece goes out. tlast marks the final result of
// each request.
// ----------------------------------------------------------------------------
module box_subtract_3d
    import bsub3_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            s_axis_tvalid,
    output logic                                            s_axis_tready,
    // a_min_x, a_min_y, a_min_z, a_max_x, a_max_y, a_max_z,
    // b_min_x, b_min_y, b_min_z, b_max_x, b_max_y, b_max_z, zero pad
    input  logic [((NUM_COORDS*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                            m_axis_tvalid,
    input  logic                                            m_axis_tready,
    // piece_min_x, piece_min_y, piece_min_z,
    // piece_max_x, piece_max_y, piece_max_z, zero pad
    output logic [((2*NUM_AXES*COORD_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
    output logic                                            m_axis_tuser,  // no_pieces
    output logic                                            m_axis_tlast   // last_piece
);

    localparam int OUT_W = ((2 * NUM_AXES * COORD_WIDTH + 7) / 8) * 8;

    logic [NUM_AXES:0]                                             vld_c;
    logic [NUM_AXES:0]                                             rdy_c;
    logic [NUM_AXES:0][NUM_AXES-1:0][COORD_WIDTH-1:0]              a_lo_c, a_hi_c;
    logic [NUM_AXES:0][NUM_AXES-1:0][COORD_WIDTH-1:0]              b_lo_c, b_hi_c;
    logic [NUM_AXES:0][NUM_AXES-1:0][COORD_WIDTH-1:0]              r_lo_c, r_hi_c;
    logic [NUM_AXES:0][NUM_SLOTS-1:0][NUM_AXES-1:0][COORD_WIDTH-1:0] p_lo_c, p_hi_c;
    slot_ctrl_t [NUM_AXES:0]                                       ctrl_c;

    logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                          pc_lo, pc_hi;

    assign vld_c[0]      = s_axis_tvalid;
    assign s_axis_tready = rdy_c[0];
    assign p_lo_c[0]     = '0;
    assign p_hi_c[0]     = '0;
    assign ctrl_c[0]     = '0;

    for (genvar d = 0; d < NUM_AXES; d++)
    begin : g_unpack
        assign a_lo_c[0][d] = s_axis_tdata[d*COORD_WIDTH +: COORD_WIDTH];
        assign a_hi_c[0][d] = s_axis_tdata[(NUM_AXES+d)*COORD_WIDTH +: COORD_WIDTH];
        assign b_lo_c[0][d] = s_axis_tdata[(2*NUM_AXES+d)*COORD_WIDTH +: COORD_WIDTH];
        assign b_hi_c[0][d] = s_axis_tdata[(3*NUM_AXES+d)*COORD_WIDTH +: COORD_WIDTH];
    end

    // remainder starts as A
    assign r_lo_c[0] = a_lo_c[0];
    assign r_hi_c[0] = a_hi_c[0];

    for (genvar g = 0; g < NUM_AXES; g++)
    begin : g_axis
        bsub3_axis_stage #(
            .COORD_WIDTH (COORD_WIDTH),
            .AXIS        (g)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld_c[g]),
            .in_ready  (rdy_c[g]),
            .in_a_lo   (a_lo_c[g]),
            .in_a_hi   (a_hi_c[g]),
            .in_b_lo   (b_lo_c[g]),
            .in_b_hi   (b_hi_c[g]),
            .in_r_lo   (r_lo_c[g]),
            .in_r_hi   (r_hi_c[g]),
            .in_p_lo   (p_lo_c[g]),
            .in_p_hi   (p_hi_c[g]),
            .in_ctrl   (ctrl_c[g]),
            .out_valid (vld_c[g+1]),
            .out_ready (rdy_c[g+1]),
            .out_a_lo  (a_lo_c[g+1]),
            .out_a_hi  (a_hi_c[g+1]),
            .out_b_lo  (b_lo_c[g+1]),
            .out_b_hi  (b_hi_c[g+1]),
            .out_r_lo  (r_lo_c[g+1]),
            .out_r_hi  (r_hi_c[g+1]),
            .out_p_lo  (p_lo_c[g+1]),
            .out_p_hi  (p_hi_c[g+1]),
            .out_ctrl  (ctrl_c[g+1])
        );
    end

    bsub3_serializer #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_c[NUM_AXES]),
        .in_ready  (rdy_c[NUM_AXES]),
        .in_p_lo   (p_lo_c[NUM_AXES]),
        .in_p_hi   (p_hi_c[NUM_AXES]),
        .in_ctrl   (ctrl_c[NUM_AXES]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_lo    (pc_lo),
        .out_hi    (pc_hi),
        .out_empty (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'({pc_hi, pc_lo});

endmodule
